// File: rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// Servo target shaper package
// Shared types, constants, the microprogram and fixed-point helpers.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int MAX_JOINTS = 8;
	localparam int JOINT_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int PC_W = 4;

	// Angle to Q8.24 turns reciprocals, applied with a shift of 28.
	localparam logic [29:0] DEG_TURN_K = 30'd11930465;
	localparam logic [29:0] RAD_TURN_K = 30'd683565276;
	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	localparam logic signed [65:0] I32_MAX_66 = 66'sd2147483647;
	localparam logic signed [65:0] I32_MIN_66 = -66'sd2147483648;
	localparam logic signed [65:0] RND_HALF_28 = 66'sd134217728;
	localparam logic signed [65:0] RND_HALF_16 = 66'sd32768;

	typedef enum logic [2:0] {
		REG_MODE_FLAGS      = 3'd0,
		REG_MAX_STEP        = 3'd1,
		REG_FILTER_ALPHA    = 3'd2,
		REG_TICK_RATE       = 3'd3,
		REG_MAX_VELOCITY    = 3'd4,
		REG_MAX_LAG         = 3'd5,
		REG_LAG_ABORT_COUNT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]  mode_flags;
		logic [30:0] max_step;
		logic [16:0] filter_alpha;
		logic [15:0] tick_rate;
		logic [30:0] max_velocity;
		logic [30:0] max_lag;
		logic [15:0] lag_abort_count;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_SEED,
		OP_CONV_MUL,
		OP_CONV_RND,
		OP_DELTA,
		OP_CLAMP,
		OP_FILT_DIFF,
		OP_FILT_MUL,
		OP_FILT_RND,
		OP_FILT_ADD,
		OP_POS_T,
		OP_VEL_DIFF,
		OP_VEL_MUL,
		OP_VEL_CLAMP,
		OP_VEL_DEF,
		OP_LAG_DIFF,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_ALWAYS,
		JMP_ALPHA_ONE,
		JMP_NO_FF
	} jump_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	typedef struct packed {
		op_t             op;
		jump_t           jump;
		logic [PC_W-1:0] target;
		logic            fin;
	} uword_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic fin;
		op_t  op;
	} dp_ctrl_t;

	typedef struct packed {
		logic alpha_one;
		logic ff_en;
	} dp_status_t;

	typedef struct packed {
		logic [31:0] position_command;
		logic [31:0] velocity_command;
		logic        step_clamped;
		logic        lag_flag;
		logic        abort_request;
		logic        last_of_tick;
	} result_t;

	// Microprogram entry points and jump targets.
	localparam logic [PC_W-1:0] PC_SEED    = 4'd0;
	localparam logic [PC_W-1:0] PC_SHAPE   = 4'd1;
	localparam logic [PC_W-1:0] PC_POS_T   = 4'd9;
	localparam logic [PC_W-1:0] PC_VEL     = 4'd10;
	localparam logic [PC_W-1:0] PC_VEL_DEF = 4'd13;
	localparam logic [PC_W-1:0] PC_LAG     = 4'd14;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{op: OP_FINISH, jump: JMP_NONE, target: PC_SEED, fin: 1'b1};
		case (pc)
			4'd0:  w = '{op: OP_SEED,      jump: JMP_NONE,      target: PC_SEED,    fin: 1'b1};
			4'd1:  w = '{op: OP_CONV_MUL,  jump: JMP_NONE,      target: PC_SEED,    fin: 1'b0};
			4'd2:  w = '{op: OP_CONV_RND,  jump: JMP_NONE,      target: PC_SEED,    fin: 1'b0};
			4'd3:  w = '{op: OP_DELTA,     jump: JMP_NONE,      target: PC_SEED,    fin: 1'b0};
			4'd4:  w = '{op: OP_CLAMP,     jump: JMP_NONE,      target: PC_SEED,    fin: 1'b0};
			4'd5:  w = '{op: OP_FILT_DIFF, jump: JMP_ALPHA_ONE, target: PC_POS_T,   fin: 1'b0};
			4'd6:  w = '{op: OP_FILT_MUL,  jump: JMP_NONE,      target: PC_SEED,    fin: 1'b0};
			4'd7:  w = '{op: OP_FILT_RND,  jump: JMP_NONE,      target: PC_SEED,    fin: 1'b0};
			4'd8:  w = '{op: OP_FILT_ADD,  jump: JMP_ALWAYS,    target: PC_VEL,     fin: 1'b0};
			4'd9:  w = '{op: OP_POS_T,     jump: JMP_NONE,      target: PC_SEED,    fin: 1'b0};
			4'd10: w = '{op: OP_VEL_DIFF,  jump: JMP_NO_FF,     target: PC_VEL_DEF, fin: 1'b0};
			4'd11: w = '{op: OP_VEL_MUL,   jump: JMP_NONE,      target: PC_SEED,    fin: 1'b0};
			4'd12: w = '{op: OP_VEL_CLAMP, jump: JMP_ALWAYS,    target: PC_LAG,     fin: 1'b0};
			4'd13: w = '{op: OP_VEL_DEF,   jump: JMP_NONE,      target: PC_SEED,    fin: 1'b0};
			4'd14: w = '{op: OP_LAG_DIFF,  jump: JMP_NONE,      target: PC_SEED,    fin: 1'b0};
			4'd15: w = '{op: OP_FINISH,    jump: JMP_NONE,      target: PC_SEED,    fin: 1'b1};
			default: w = '{op: OP_FINISH,  jump: JMP_NONE,      target: PC_SEED,    fin: 1'b1};
		endcase
		return w;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > I32_MAX_66) begin
			r = 32'sh7FFFFFFF;
		end else if (v < I32_MIN_66) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Joint index folded into the table range by repeated subtraction.
	function automatic logic [JOINT_W-1:0] joint_slot(input logic [2:0] idx);
		logic [4:0] v;
		v = {2'b00, idx};
		for (int i = 0; i < 8; i++) begin
			if (v >= 5'(MAX_JOINTS)) begin
				v = v - 5'(MAX_JOINTS);
			end
		end
		return v[JOINT_W-1:0];
	endfunction

endpackage

// File: rtl/sts_cfg_regs.sv
// ----------------------------------------------------------------------------
// Servo target shaper configuration registers
// Write-only register file loaded from the configuration channel.
// ----------------------------------------------------------------------------
module sts_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output sts_pkg::cfg_t cfg
);
	import sts_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_flags      <= 3'd1;
			cfg_q.max_step        <= 31'd134936;
			cfg_q.filter_alpha    <= 17'd65536;
			cfg_q.tick_rate       <= 16'd100;
			cfg_q.max_velocity    <= 31'd2670177;
			cfg_q.max_lag         <= 31'd0;
			cfg_q.lag_abort_count <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MODE_FLAGS:      cfg_q.mode_flags      <= cfg_data[2:0];
				REG_MAX_STEP:        cfg_q.max_step        <= cfg_data[30:0];
				REG_FILTER_ALPHA:    cfg_q.filter_alpha    <= cfg_data[16:0];
				REG_TICK_RATE:       cfg_q.tick_rate       <= cfg_data[15:0];
				REG_MAX_VELOCITY:    cfg_q.max_velocity    <= cfg_data[30:0];
				REG_MAX_LAG:         cfg_q.max_lag         <= cfg_data[30:0];
				REG_LAG_ABORT_COUNT: cfg_q.lag_abort_count <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/sts_sequencer.sv
// ----------------------------------------------------------------------------
// Servo target shaper sequencer
// Step counter over the control store, with conditional jumps.
// ----------------------------------------------------------------------------
module sts_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd_shape,
	input  logic                out_free,
	input  sts_pkg::dp_status_t status,
	output sts_pkg::dp_ctrl_t   ctrl
);
	import sts_pkg::*;

	seq_state_t      state_q, state_n;
	logic [PC_W-1:0] pc_q, pc_n;
	uword_t          uw;
	logic            load, exec, taken;

	assign uw = ucode(pc_q);
	assign in_ready = (state_q == SEQ_IDLE);
	assign load = in_valid && in_ready;
	// The last step waits until the output register can take the result.
	assign exec = (state_q == SEQ_RUN) && !(uw.fin && !out_free);
	assign ctrl = '{load: load, exec: exec, fin: uw.fin, op: uw.op};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			pc_q    <= PC_SEED;
		end else begin
			state_q <= state_n;
			pc_q    <= pc_n;
		end
	end

	always_comb begin
		case (uw.jump)
			JMP_NONE:      taken = 1'b0;
			JMP_ALWAYS:    taken = 1'b1;
			JMP_ALPHA_ONE: taken = status.alpha_one;
			JMP_NO_FF:     taken = !status.ff_en;
			default:       taken = 1'b0;
		endcase

		state_n = state_q;
		pc_n = pc_q;
		case (state_q)
			SEQ_IDLE: begin
				if (load) begin
					state_n = SEQ_RUN;
					pc_n = cmd_shape ? PC_SHAPE : PC_SEED;
				end
			end
			SEQ_RUN: begin
				if (exec) begin
					if (uw.fin) begin
						state_n = SEQ_IDLE;
					end else if (taken) begin
						pc_n = uw.target;
					end else begin
						pc_n = pc_q + 4'd1;
					end
				end
			end
			default: state_n = SEQ_IDLE;
		endcase
	end

endmodule

// File: rtl/sts_datapath.sv
// ----------------------------------------------------------------------------
// Servo target shaper datapath
// Shared multiplier, rounder and subtractor, joint state tables and tick flags.
// ----------------------------------------------------------------------------
module sts_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sts_pkg::dp_ctrl_t   ctrl,
	input  sts_pkg::cfg_t       cfg,
	input  logic [2:0]          joint_index,
	input  logic                last_joint,
	input  logic [31:0]         target_angle,
	input  logic [31:0]         feedback_position,
	input  logic                feedback_valid,
	output sts_pkg::dp_status_t status,
	output sts_pkg::result_t    result
);
	import sts_pkg::*;

	logic [31:0] prev_mem [MAX_JOINTS];
	logic [31:0] filt_mem [MAX_JOINTS];

	logic [JOINT_W-1:0] j_q;
	logic               last_q, fbv_q;
	logic signed [31:0] angle_q, fb_q;
	logic signed [31:0] prev_q, filt_q, t_q, pos_q, vel_q;
	logic signed [32:0] d_q;
	logic signed [65:0] p_q;
	logic               clamp_seen_q, lag_seen_q;
	logic [15:0]        streak_q;

	logic [29:0]        conv_k;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] product;
	logic signed [65:0] rnd_half, rnd_sum, rnd28, rnd16;
	logic signed [31:0] sub_a, sub_b;
	logic signed [32:0] sub_res;
	logic signed [33:0] d34, step34, prev34, clamp_sum, ml34;
	logic               clamp_hi, clamp_lo;
	logic signed [65:0] vmax66;
	logic signed [31:0] vmax32;
	logic               lag_now, lag_next, abort_hit;
	logic [15:0]        streak_inc;

	assign status.alpha_one = (cfg.filter_alpha >= ALPHA_ONE);
	assign status.ff_en = cfg.mode_flags[2];

	assign conv_k = cfg.mode_flags[0] ? RAD_TURN_K : DEG_TURN_K;

	always_comb begin
		mul_a = d_q;
		mul_b = 33'sd0;
		case (ctrl.op)
			OP_CONV_MUL: begin
				mul_a = {angle_q[31], angle_q};
				mul_b = $signed({3'b000, conv_k});
			end
			OP_FILT_MUL: mul_b = $signed({16'd0, cfg.filter_alpha});
			OP_VEL_MUL:  mul_b = $signed({17'd0, cfg.tick_rate});
			default: ;
		endcase
	end

	assign product = mul_a * mul_b;

	// Round half away from zero: a negative value takes one less before the shift.
	assign rnd_half = (ctrl.op == OP_CONV_RND) ? RND_HALF_28 : RND_HALF_16;
	assign rnd_sum = p_q + rnd_half - $signed({65'd0, p_q[65]});
	assign rnd28 = rnd_sum >>> 28;
	assign rnd16 = rnd_sum >>> 16;

	always_comb begin
		sub_a = t_q;
		sub_b = prev_q;
		case (ctrl.op)
			OP_FILT_DIFF: begin
				sub_a = t_q;
				sub_b = filt_q;
			end
			OP_VEL_DIFF: begin
				sub_a = pos_q;
				sub_b = filt_q;
			end
			OP_LAG_DIFF: begin
				sub_a = fb_q;
				sub_b = pos_q;
			end
			default: ;
		endcase
	end

	assign sub_res = $signed({sub_a[31], sub_a}) - $signed({sub_b[31], sub_b});

	assign d34 = {d_q[32], d_q};
	assign step34 = $signed({3'b000, cfg.max_step});
	assign prev34 = {{2{prev_q[31]}}, prev_q};
	assign clamp_hi = d34 > step34;
	assign clamp_lo = d34 < -step34;
	assign clamp_sum = clamp_hi ? (prev34 + step34) : (prev34 - step34);

	assign vmax66 = $signed({35'd0, cfg.max_velocity});
	assign vmax32 = $signed({1'b0, cfg.max_velocity});

	assign ml34 = $signed({3'b000, cfg.max_lag});
	assign lag_now = (cfg.max_lag != 31'd0) && fbv_q && ((d34 > ml34) || (d34 < -ml34));
	assign lag_next = lag_seen_q || lag_now;

	always_comb begin
		if (!lag_next) begin
			streak_inc = 16'd0;
		end else if (streak_q == 16'hFFFF) begin
			streak_inc = streak_q;
		end else begin
			streak_inc = streak_q + 16'd1;
		end
	end

	assign abort_hit = (cfg.lag_abort_count != 16'd0) && (streak_inc >= cfg.lag_abort_count);

	always_comb begin
		if (ctrl.op == OP_SEED) begin
			result = '{position_command: fb_q, velocity_command: 32'd0, step_clamped: 1'b0,
				lag_flag: 1'b0, abort_request: 1'b0, last_of_tick: last_q};
		end else begin
			result = '{position_command: pos_q, velocity_command: vel_q,
				step_clamped: clamp_seen_q, lag_flag: lag_next,
				abort_request: last_q && abort_hit, last_of_tick: last_q};
		end
	end

	// Input capture and working registers.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			j_q     <= joint_slot(joint_index);
			last_q  <= last_joint;
			angle_q <= $signed(target_angle);
			fb_q    <= $signed(feedback_position);
			fbv_q   <= feedback_valid;
		end
		if (ctrl.exec) begin
			case (ctrl.op)
				OP_CONV_MUL: begin
					p_q    <= product;
					prev_q <= $signed(prev_mem[j_q]);
					filt_q <= $signed(filt_mem[j_q]);
				end
				OP_CONV_RND: t_q <= sat32(rnd28);
				OP_DELTA:    d_q <= sub_res;
				OP_CLAMP: begin
					if (clamp_hi || clamp_lo) begin
						t_q <= sat32({{32{clamp_sum[33]}}, clamp_sum});
					end
				end
				OP_FILT_DIFF: d_q <= sub_res;
				OP_FILT_MUL:  p_q <= product;
				OP_FILT_RND:  d_q <= rnd16[32:0];
				OP_FILT_ADD:  pos_q <= filt_q + d_q[31:0];
				OP_POS_T:     pos_q <= t_q;
				OP_VEL_DIFF:  d_q <= sub_res;
				OP_VEL_MUL:   p_q <= product;
				OP_VEL_CLAMP: begin
					if (p_q > vmax66) begin
						vel_q <= vmax32;
					end else if (p_q < -vmax66) begin
						vel_q <= -vmax32;
					end else begin
						vel_q <= p_q[31:0];
					end
				end
				OP_VEL_DEF:  vel_q <= cfg.mode_flags[1] ? 32'sd0 : vmax32;
				OP_LAG_DIFF: d_q <= sub_res;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			if (ctrl.op == OP_SEED) begin
				prev_mem[j_q] <= fb_q;
				filt_mem[j_q] <= fb_q;
			end else if (ctrl.op == OP_FINISH) begin
				prev_mem[j_q] <= t_q;
				filt_mem[j_q] <= pos_q;
			end
		end
	end

	// Tick flags and the lag streak.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_seen_q <= 1'b0;
			lag_seen_q   <= 1'b0;
			streak_q     <= 16'd0;
		end else if (ctrl.exec) begin
			case (ctrl.op)
				OP_SEED: begin
					clamp_seen_q <= 1'b0;
					lag_seen_q   <= 1'b0;
					streak_q     <= 16'd0;
				end
				OP_CLAMP: begin
					if (clamp_hi || clamp_lo) begin
						clamp_seen_q <= 1'b1;
					end
				end
				OP_FINISH: begin
					if (last_q) begin
						clamp_seen_q <= 1'b0;
						lag_seen_q   <= 1'b0;
						streak_q     <= abort_hit ? 16'd0 : streak_inc;
					end else begin
						lag_seen_q <= lag_next;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/servo_target_shaper_top.sv
// ----------------------------------------------------------------------------
// Servo target shaper
// Slew limit, first-order low-pass, velocity and lag check for one joint item.
// ----------------------------------------------------------------------------
// A seed item takes 1 step, a shape item 10 to 13 steps of the microprogram,
// which share one multiplier and rounder. A new item is taken only in idle,
// after the last step of the one before; the next item is accepted while the
// result waits in the output register.
// Reset clears the sequencer, tick flags and lag streak and loads the configuration defaults;
// the joint tables hold no reset value and must be seeded before shaping.
module servo_target_shaper_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// joint_index[2:0], target_angle[34:3], feedback_position[66:35],
	// feedback_valid[67], zero[71:68]
	input  logic [71:0] s_axis_tdata,
	// command[0]
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// position_command[31:0], velocity_command[63:32], step_clamped[64],
	// lag_flag[65], abort_request[66], zero[71:67]
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import sts_pkg::*;

	cfg_t       cfg;
	dp_ctrl_t   ctrl;
	dp_status_t status;
	result_t    result;
	result_t    res_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_axis_tready;

	sts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sts_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd_shape (s_axis_tuser),
		.out_free  (out_free),
		.status    (status),
		.ctrl      (ctrl)
	);

	sts_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.cfg               (cfg),
		.joint_index       (s_axis_tdata[2:0]),
		.last_joint        (s_axis_tlast),
		.target_angle      (s_axis_tdata[34:3]),
		.feedback_position (s_axis_tdata[66:35]),
		.feedback_valid    (s_axis_tdata[67]),
		.status            (status),
		.result            (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.exec && ctrl.fin) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec && ctrl.fin) begin
			res_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast = res_q.last_of_tick;
	assign m_axis_tdata = {5'd0, res_q.abort_request, res_q.lag_flag, res_q.step_clamped,
		res_q.velocity_command, res_q.position_command};

endmodule
